FILE: design/gei_pkg.sv
package gei_pkg;

  // Number of input lines handled by the unit
  localparam int NUM_LINES = 32;
  localparam int PIN_W     = 5;
  localparam int LINE_W    = 32;
  localparam int TICKS_W   = 8;
  localparam int GROUP_W   = 8;
  localparam int IRQ_W     = 4;

  // Mask of lines that exist
  localparam logic [LINE_W-1:0] LINE_MASK =
    LINE_W'((64'd1 << NUM_LINES) - 64'd1);

  localparam logic [TICKS_W-1:0] FILTER_TICKS_RESET = 8'd5;

  // Request kinds
  localparam logic [1:0] ACT_PIN   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 3'd4;

  typedef struct packed {
    logic [LINE_W-1:0]  irq_enable;
    logic [LINE_W-1:0]  rise_enable;
    logic [LINE_W-1:0]  fall_enable;
    logic [LINE_W-1:0]  filter_enable;
    logic [TICKS_W-1:0] filter_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [PIN_W-1:0]  pin;
    logic              level;
    logic [LINE_W-1:0] clear_mask;
  } req_t;

  typedef struct packed {
    logic [LINE_W-1:0] pending;
    logic [IRQ_W-1:0]  irq_lines;
  } rsp_t;

  // Interrupt lines from the enabled pending bits
  function automatic logic [IRQ_W-1:0] irq_map(input logic [LINE_W-1:0] act);
    logic [IRQ_W-1:0] r;
    r[0] = |act;
    r[1] = |act[2*GROUP_W-1:GROUP_W];
    r[2] = |act[3*GROUP_W-1:2*GROUP_W];
    r[3] = |act[4*GROUP_W-1:3*GROUP_W];
    return r;
  endfunction

endpackage

FILE: design/gei_cfg.sv
module gei_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gei_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gei_pkg::LINE_W-1:0]      cfg_wdata,
  output gei_pkg::cfg_t                   cfg
);

  gei_pkg::cfg_t cfg_r;
  gei_pkg::cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gei_pkg::REG_IRQ_EN:    cfg_nxt.irq_enable    = cfg_wdata;
        gei_pkg::REG_RISE_EN:   cfg_nxt.rise_enable   = cfg_wdata;
        gei_pkg::REG_FALL_EN:   cfg_nxt.fall_enable   = cfg_wdata;
        gei_pkg::REG_FILTER_EN: cfg_nxt.filter_enable = cfg_wdata;
        gei_pkg::REG_TICKS:     cfg_nxt.filter_ticks  = cfg_wdata[gei_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.irq_enable    <= '0;
      cfg_r.rise_enable   <= '0;
      cfg_r.fall_enable   <= '0;
      cfg_r.filter_enable <= '0;
      cfg_r.filter_ticks  <= gei_pkg::FILTER_TICKS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/gei_core.sv
module gei_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_fire,
  input  gei_pkg::req_t  req,
  input  gei_pkg::cfg_t  cfg,
  output gei_pkg::rsp_t  rsp_nxt,
  output logic           filter_armed,
  output logic [gei_pkg::TICKS_W-1:0] filter_count
);

  logic [gei_pkg::LINE_W-1:0]  levels_r,  levels_nxt;
  logic [gei_pkg::LINE_W-1:0]  pending_r, pending_nxt;
  logic                        armed_r,   armed_nxt;
  logic [gei_pkg::PIN_W-1:0]   fline_r,   fline_nxt;
  logic                        target_r,  target_nxt;
  logic [gei_pkg::TICKS_W-1:0] count_r,   count_nxt;

  logic [gei_pkg::LINE_W-1:0] pin_bit;
  logic [gei_pkg::LINE_W-1:0] fbit;
  logic                       pin_ok;
  logic                       prev;
  logic                       fire_rise;
  logic                       fire_fall;
  logic                       flvl;
  logic                       fedge_ok;

  assign pin_bit   = gei_pkg::LINE_W'(1) << req.pin;
  assign fbit      = gei_pkg::LINE_W'(1) << fline_r;
  assign pin_ok    = {1'b0, req.pin} < (gei_pkg::PIN_W+1)'(gei_pkg::NUM_LINES);
  assign prev      = levels_r[req.pin];
  assign fire_rise = !prev && req.level && cfg.rise_enable[req.pin];
  assign fire_fall = prev && !req.level && cfg.fall_enable[req.pin];
  assign flvl      = levels_r[fline_r];
  assign fedge_ok  = (flvl == target_r) &&
                     (flvl ? cfg.rise_enable[fline_r] : cfg.fall_enable[fline_r]);

  // Next state for one request
  always_comb begin
    levels_nxt  = levels_r;
    pending_nxt = pending_r;
    armed_nxt   = armed_r;
    fline_nxt   = fline_r;
    target_nxt  = target_r;
    count_nxt   = count_r;
    case (req.action)
      gei_pkg::ACT_PIN: begin
        if (pin_ok) begin
          levels_nxt = (req.level ? (levels_r | pin_bit) : (levels_r & ~pin_bit))
                       & gei_pkg::LINE_MASK;
          if (cfg.irq_enable[req.pin]) begin
            if (cfg.filter_enable[req.pin]) begin
              // arm the filter slot, replacing any earlier arming
              armed_nxt  = 1'b1;
              fline_nxt  = req.pin;
              target_nxt = req.level;
              count_nxt  = (cfg.filter_ticks == '0) ? gei_pkg::TICKS_W'(1)
                                                    : cfg.filter_ticks;
            end else if (fire_rise || fire_fall) begin
              pending_nxt = pending_r | pin_bit;
            end
          end
        end
      end
      gei_pkg::ACT_CLEAR: begin
        pending_nxt = pending_r & ~req.clear_mask;
      end
      gei_pkg::ACT_TICK: begin
        if (armed_r) begin
          if (count_r > gei_pkg::TICKS_W'(1)) begin
            count_nxt = count_r - gei_pkg::TICKS_W'(1);
          end else begin
            // slot expires: confirm only if the line is at its target level and that edge is enabled
            count_nxt = '0;
            armed_nxt = 1'b0;
            if (fedge_ok) pending_nxt = (pending_r | fbit) & gei_pkg::LINE_MASK;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r  <= '0;
      pending_r <= '0;
      armed_r   <= 1'b0;
      fline_r   <= '0;
      target_r  <= 1'b0;
      count_r   <= '0;
    end else if (req_fire) begin
      levels_r  <= levels_nxt;
      pending_r <= pending_nxt;
      armed_r   <= armed_nxt;
      fline_r   <= fline_nxt;
      target_r  <= target_nxt;
      count_r   <= count_nxt;
    end
  end

  assign rsp_nxt.pending   = pending_nxt;
  assign rsp_nxt.irq_lines = gei_pkg::irq_map(pending_nxt & cfg.irq_enable);
  assign filter_armed      = armed_r;
  assign filter_count      = count_r;

endmodule

FILE: design/gei_out.sv
module gei_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  gei_pkg::rsp_t  rsp_nxt,
  input  logic           out_tready,
  output logic           out_tvalid,
  output gei_pkg::rsp_t  rsp,
  output logic           free
);

  logic          valid_r;
  gei_pkg::rsp_t rsp_r;

  // Slot is free when empty or being drained this cycle
  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rsp_r <= rsp_nxt;
  end

  assign out_tvalid = valid_r;
  assign rsp        = rsp_r;

endmodule

FILE: design/gpio_edge_interrupt_unit.sv
// Channel  | Direction | Payload
// in_      | slave     | tuser: action[1:0]; tdata: pin, level, clear_mask
// out_     | master    | tdata: pending, irq_lines
// cfg_     | write     | cfg_index selects register, cfg_wdata value
//
// One request per clock while in_tready is high; each result is registered and appears in the cycle after its request.
// The state update and the result are computed in a single pass between the
// request handshake and the result register.
// rst_n is synchronous, active low; config resets to zero, filter ticks to 5.
// in_tready drops only while a result sits in the output register unclaimed.
module gpio_edge_interrupt_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [1:0]                    in_tuser,   // action[1:0]
  input  logic [39:0]                   in_tdata,   // pin[4:0], level[5], clear_mask[37:6]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // pending[31:0], irq_lines[35:32]
  input  logic                          cfg_we,
  input  logic [gei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gei_pkg::LINE_W-1:0]    cfg_wdata
);

  gei_pkg::cfg_t cfg;
  gei_pkg::req_t req;
  gei_pkg::rsp_t rsp_nxt;
  gei_pkg::rsp_t rsp;
  logic          req_fire;
  logic          free;
  logic          filter_armed;
  logic [gei_pkg::TICKS_W-1:0] filter_count;

  // Unpack the request
  assign req.action     = in_tuser;
  assign req.pin        = in_tdata[4:0];
  assign req.level      = in_tdata[5];
  assign req.clear_mask = in_tdata[37:6];

  assign in_tready = free;
  assign req_fire  = in_tvalid && free;

  gei_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gei_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_fire     (req_fire),
    .req          (req),
    .cfg          (cfg),
    .rsp_nxt      (rsp_nxt),
    .filter_armed (filter_armed),
    .filter_count (filter_count)
  );

  gei_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (req_fire),
    .rsp_nxt    (rsp_nxt),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .rsp        (rsp),
    .free       (free)
  );

  assign out_tdata = {4'd0, rsp.irq_lines, rsp.pending};

`ifndef SYNTHESIS
  // An armed filter slot always has ticks left
  a_armed_count: assert property (@(posedge clk) disable iff (!rst_n)
    filter_armed |-> (filter_count != '0))
    else $error("filter slot armed with zero count");

  // Every accepted request shows a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> out_tvalid)
    else $error("accepted request produced no result");

  // Backpressure only while a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  // Summary line follows the enabled pending bits
  a_irq_any: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $stable(cfg.irq_enable) && !$past(cfg_we)) |->
      (rsp.irq_lines[0] == |(rsp.pending & cfg.irq_enable)))
    else $error("irq line 0 disagrees with pending status");
`endif

endmodule
